FILE: hw/rtl/rms_pkg.sv
`default_nettype none

package rms_pkg;

    // Default parameter values
    localparam int COORD_WIDTH_DEF = 16;
    localparam int TIMER_WIDTH_DEF = 24;

    // Fixed field widths
    localparam int PORT_COORD_W = 16;
    localparam int TIMEOUT_W    = 24;
    localparam int APB_DATA_W   = 32;
    localparam int APB_ADDR_W   = 3;

    // Register word index of the no-path timeout
    localparam logic REG_NO_PATH_TIMEOUT = 1'b0;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 24'd4000;

    // Mission phases
    localparam logic [2:0] PH_SEARCH     = 3'd0;
    localparam logic [2:0] PH_FOLLOW     = 3'd1;
    localparam logic [2:0] PH_PRE_NOPATH = 3'd2;
    localparam logic [2:0] PH_NOPATH     = 3'd3;
    localparam logic [2:0] PH_DONE       = 3'd4;

    // Sub-steps
    localparam logic [2:0] SS_SEARCH     = 3'd0;
    localparam logic [2:0] SS_SENSE      = 3'd1;
    localparam logic [2:0] SS_WAIT_ANGLE = 3'd2;
    localparam logic [2:0] SS_TO_VICTIM  = 3'd3;
    localparam logic [2:0] SS_WAIT_DONE  = 3'd4;
    localparam logic [2:0] SS_TO_HOME    = 3'd5;

    // Driver selection
    localparam logic [1:0] DRV_NONE   = 2'd0;
    localparam logic [1:0] DRV_WALL   = 2'd1;
    localparam logic [1:0] DRV_VICTIM = 2'd2;
    localparam logic [1:0] DRV_PATH   = 2'd3;

    // Per-tick helper flags
    typedef struct packed {
        logic victim_seen;
        logic angle_wanted;
        logic path_lost;
        logic path_done;
    } tick_flags_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rms_cfg.sv
`default_nettype none

module rms_cfg (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [rms_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire logic [rms_pkg::APB_DATA_W-1:0]      pwdata,
    output logic      [rms_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                     pready,
    output logic      [rms_pkg::TIMEOUT_W-1:0]       no_path_timeout
);

    logic [rms_pkg::TIMEOUT_W-1:0] timeout_reg;
    logic [rms_pkg::TIMEOUT_W-1:0] timeout_next;
    logic                          hit;
    logic                          wr_en;

    // Decode the register word
    assign hit   = (paddr[rms_pkg::APB_ADDR_W-1] == rms_pkg::REG_NO_PATH_TIMEOUT);
    assign wr_en = psel && penable && pwrite && pready && hit;

    assign pready = 1'b1;

    // Update the timeout on a write transaction
    always_comb
    begin
        timeout_next = timeout_reg;
        if (wr_en)
        begin
            timeout_next = pwdata[rms_pkg::TIMEOUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= rms_pkg::TIMEOUT_RESET;
        end
        else
        begin
            timeout_reg <= timeout_next;
        end
    end

    // Return the register on read, zero elsewhere
    always_comb
    begin
        prdata = '0;
        if (hit)
        begin
            prdata = rms_pkg::APB_DATA_W'(timeout_reg);
        end
    end

    assign no_path_timeout = timeout_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/rms_seq.sv
`default_nettype none

module rms_seq #(
    parameter int COORD_WIDTH = rms_pkg::COORD_WIDTH_DEF,
    parameter int TIMER_WIDTH = rms_pkg::TIMER_WIDTH_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   step_en,
    input  wire rms_pkg::tick_flags_t                   flags,
    input  wire logic signed [rms_pkg::PORT_COORD_W-1:0] seen_x,
    input  wire logic signed [rms_pkg::PORT_COORD_W-1:0] seen_y,
    input  wire logic signed [rms_pkg::PORT_COORD_W-1:0] home_x,
    input  wire logic signed [rms_pkg::PORT_COORD_W-1:0] home_y,
    input  wire logic        [rms_pkg::TIMEOUT_W-1:0]    no_path_timeout,
    output logic             [2:0]                       phase,
    output logic             [2:0]                       substep,
    output logic             [1:0]                       drive,
    output logic                                         carrying,
    output logic             [COORD_WIDTH-1:0]           target_x,
    output logic             [COORD_WIDTH-1:0]           target_y
);

    localparam int CMP_W = (TIMER_WIDTH > rms_pkg::TIMEOUT_W) ? TIMER_WIDTH
                                                              : rms_pkg::TIMEOUT_W;

    logic [2:0]             phase_reg,    phase_next;
    logic [2:0]             substep_reg,  substep_next;
    logic [1:0]             drive_reg,    drive_next;
    logic                   carry_reg,    carry_next;
    logic [COORD_WIDTH-1:0] tgt_x_reg,    tgt_x_next;
    logic [COORD_WIDTH-1:0] tgt_y_reg,    tgt_y_next;
    logic [TIMER_WIDTH-1:0] ticks_reg,    ticks_next;

    logic [TIMER_WIDTH-1:0] ticks_sat;
    logic                   timed_out;
    logic [COORD_WIDTH-1:0] vx_ext, vy_ext, hx_ext, hy_ext;

    // Sign-extend or trim coordinates to the stored width
    assign vx_ext = COORD_WIDTH'(seen_x);
    assign vy_ext = COORD_WIDTH'(seen_y);
    assign hx_ext = COORD_WIDTH'(home_x);
    assign hy_ext = COORD_WIDTH'(home_y);

    // Saturating tick count, also the elapsed time in the no-path phase
    assign ticks_sat = (&ticks_reg) ? ticks_reg : ticks_reg + TIMER_WIDTH'(1);
    assign timed_out = (CMP_W'(ticks_sat) >= CMP_W'(no_path_timeout));

    // Next-state logic for one tick
    always_comb
    begin
        phase_next   = phase_reg;
        substep_next = substep_reg;
        drive_next   = drive_reg;
        carry_next   = carry_reg;
        tgt_x_next   = tgt_x_reg;
        tgt_y_next   = tgt_y_reg;

        unique case (phase_reg)
            rms_pkg::PH_SEARCH:
            begin
                if (flags.victim_seen)
                begin
                    phase_next   = rms_pkg::PH_FOLLOW;
                    substep_next = rms_pkg::SS_TO_VICTIM;
                    drive_next   = rms_pkg::DRV_NONE;
                    tgt_x_next   = vx_ext;
                    tgt_y_next   = vy_ext;
                    carry_next   = 1'b1;
                end
                else if (substep_reg == rms_pkg::SS_SEARCH)
                begin
                    drive_next = rms_pkg::DRV_WALL;
                    if (flags.angle_wanted)
                    begin
                        substep_next = rms_pkg::SS_SENSE;
                        drive_next   = rms_pkg::DRV_VICTIM;
                    end
                end
                else if (substep_reg == rms_pkg::SS_SENSE)
                begin
                    if (!flags.angle_wanted)
                    begin
                        substep_next = rms_pkg::SS_WAIT_ANGLE;
                        drive_next   = rms_pkg::DRV_NONE;
                    end
                end
                else if (substep_reg == rms_pkg::SS_WAIT_ANGLE)
                begin
                    if (!flags.angle_wanted)
                    begin
                        substep_next = rms_pkg::SS_SEARCH;
                        drive_next   = rms_pkg::DRV_WALL;
                    end
                end
                else
                begin
                    phase_next   = rms_pkg::PH_SEARCH;
                    substep_next = rms_pkg::SS_SEARCH;
                    drive_next   = rms_pkg::DRV_NONE;
                    carry_next   = 1'b0;
                end
            end
            rms_pkg::PH_FOLLOW:
            begin
                if (flags.path_lost)
                begin
                    phase_next = rms_pkg::PH_PRE_NOPATH;
                    drive_next = rms_pkg::DRV_NONE;
                end
                else if (substep_reg == rms_pkg::SS_TO_VICTIM)
                begin
                    drive_next = rms_pkg::DRV_PATH;
                    if (flags.path_done)
                    begin
                        substep_next = rms_pkg::SS_WAIT_DONE;
                        drive_next   = rms_pkg::DRV_NONE;
                    end
                end
                else if (substep_reg == rms_pkg::SS_WAIT_DONE)
                begin
                    if (!flags.path_done)
                    begin
                        substep_next = rms_pkg::SS_TO_HOME;
                        tgt_x_next   = hx_ext;
                        tgt_y_next   = hy_ext;
                        carry_next   = 1'b0;
                    end
                end
                else if (substep_reg == rms_pkg::SS_TO_HOME)
                begin
                    drive_next = rms_pkg::DRV_PATH;
                    if (flags.path_done)
                    begin
                        phase_next = rms_pkg::PH_DONE;
                        drive_next = rms_pkg::DRV_NONE;
                    end
                end
                else
                begin
                    phase_next   = rms_pkg::PH_SEARCH;
                    substep_next = rms_pkg::SS_SEARCH;
                    drive_next   = rms_pkg::DRV_NONE;
                    carry_next   = 1'b0;
                end
            end
            rms_pkg::PH_PRE_NOPATH:
            begin
                if (!flags.path_lost)
                begin
                    phase_next = rms_pkg::PH_NOPATH;
                    drive_next = rms_pkg::DRV_WALL;
                end
            end
            rms_pkg::PH_NOPATH:
            begin
                if (timed_out)
                begin
                    phase_next = rms_pkg::PH_FOLLOW;
                    drive_next = rms_pkg::DRV_NONE;
                end
            end
            rms_pkg::PH_DONE:
            begin
                phase_next = rms_pkg::PH_DONE;
            end
            default:
            begin
                phase_next   = rms_pkg::PH_SEARCH;
                substep_next = rms_pkg::SS_SEARCH;
                drive_next   = rms_pkg::DRV_NONE;
                carry_next   = 1'b0;
            end
        endcase
    end

    // Clear the tick count on a phase change, else count up and saturate
    assign ticks_next = (phase_next != phase_reg) ? '0 : ticks_sat;

    // Commit the tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= rms_pkg::PH_SEARCH;
            substep_reg <= rms_pkg::SS_SEARCH;
            drive_reg   <= rms_pkg::DRV_NONE;
            carry_reg   <= 1'b0;
            tgt_x_reg   <= '0;
            tgt_y_reg   <= '0;
            ticks_reg   <= '0;
        end
        else if (step_en)
        begin
            phase_reg   <= phase_next;
            substep_reg <= substep_next;
            drive_reg   <= drive_next;
            carry_reg   <= carry_next;
            tgt_x_reg   <= tgt_x_next;
            tgt_y_reg   <= tgt_y_next;
            ticks_reg   <= ticks_next;
        end
    end

    assign phase    = phase_reg;
    assign substep  = substep_reg;
    assign drive    = drive_reg;
    assign carrying = carry_reg;
    assign target_x = tgt_x_reg;
    assign target_y = tgt_y_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/rescue_mission_sequencer_core.sv
`default_nettype none

// Mission sequencer for a search robot: one tick transaction in, one result out.
// Input channel: in_valid/in_stall carry the sensor and helper flags, victim
// position and home position of one control tick. Output channel:
// out_valid/out_stall carry the selected driver, goal, goal kind, phase and
// sub-step as they stand after that tick.
// A tick accepted into the input register is stepped into the state registers,
// which present its result, once the result slot is free or drains.
// Throughput: one tick per cycle while results are taken; the whole tick update is
// one level of next-state logic between the input register and the state registers.
// The state registers double as the result register: they only move when
// a new result is loaded, so a stalled result holds.
// When the receiver stalls, the result holds, one more tick waits in the
// input register, and in_stall rises until the result is taken.
// The APB port holds the no-path timeout (byte address 0); the user writes it only while
// idle, which the block itself does not enforce. Reset: phase search, driver none, goal zero,
// timeout 4000, both channels empty.
module rescue_mission_sequencer_core #(
    parameter int COORD_WIDTH = rms_pkg::COORD_WIDTH_DEF,
    parameter int TIMER_WIDTH = rms_pkg::TIMER_WIDTH_DEF
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     psel,
    input  wire logic                                     penable,
    input  wire logic                                     pwrite,
    input  wire logic        [rms_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic        [rms_pkg::APB_DATA_W-1:0]    pwdata,
    output logic             [rms_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                          pready,
    input  wire logic                                     in_valid,
    output logic                                          in_stall,
    input  wire logic                                     victim_seen,
    input  wire logic signed [rms_pkg::PORT_COORD_W-1:0]  victim_pos_x,
    input  wire logic signed [rms_pkg::PORT_COORD_W-1:0]  victim_pos_y,
    input  wire logic                                     angle_wanted,
    input  wire logic                                     path_lost,
    input  wire logic                                     path_done,
    input  wire logic signed [rms_pkg::PORT_COORD_W-1:0]  home_x,
    input  wire logic signed [rms_pkg::PORT_COORD_W-1:0]  home_y,
    output logic                                          out_valid,
    input  wire logic                                     out_stall,
    output logic             [1:0]                        driver_select,
    output logic signed      [rms_pkg::PORT_COORD_W-1:0]  goal_x,
    output logic signed      [rms_pkg::PORT_COORD_W-1:0]  goal_y,
    output logic                                          goal_is_victim,
    output logic             [2:0]                        phase_now,
    output logic             [2:0]                        substep_now
);

    logic [rms_pkg::TIMEOUT_W-1:0] no_path_timeout;

    logic                                in_vld_reg, in_vld_next;
    logic                                out_vld_reg, out_vld_next;
    rms_pkg::tick_flags_t                flags_reg;
    logic signed [rms_pkg::PORT_COORD_W-1:0] vx_reg, vy_reg, hx_reg, hy_reg;

    logic                   load;
    logic                   advance;
    logic [2:0]             phase;
    logic [2:0]             substep;
    logic [1:0]             drive;
    logic                   carrying;
    logic [COORD_WIDTH-1:0] target_x;
    logic [COORD_WIDTH-1:0] target_y;

    // Configuration register
    rms_cfg u_cfg (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .no_path_timeout (no_path_timeout)
    );

    // Handshake: step the sequencer when the result slot is free or drains
    assign advance     = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall    = in_vld_reg && !advance;
    assign load        = in_valid && !in_stall;
    assign in_vld_next = load || (in_vld_reg && !advance);
    assign out_vld_next = advance || (out_vld_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Capture the tick transaction
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            flags_reg.victim_seen  <= victim_seen;
            flags_reg.angle_wanted <= angle_wanted;
            flags_reg.path_lost    <= path_lost;
            flags_reg.path_done    <= path_done;
            vx_reg                 <= victim_pos_x;
            vy_reg                 <= victim_pos_y;
            hx_reg                 <= home_x;
            hy_reg                 <= home_y;
        end
    end

    // Mission state and tick update
    rms_seq #(
        .COORD_WIDTH (COORD_WIDTH),
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_seq (
        .clk             (clk),
        .rst_n           (rst_n),
        .step_en         (advance),
        .flags           (flags_reg),
        .seen_x          (vx_reg),
        .seen_y          (vy_reg),
        .home_x          (hx_reg),
        .home_y          (hy_reg),
        .no_path_timeout (no_path_timeout),
        .phase           (phase),
        .substep         (substep),
        .drive           (drive),
        .carrying        (carrying),
        .target_x        (target_x),
        .target_y        (target_y)
    );

    // Drive the result
    assign out_valid      = out_vld_reg;
    assign driver_select  = drive;
    assign goal_x         = rms_pkg::PORT_COORD_W'(target_x);
    assign goal_y         = rms_pkg::PORT_COORD_W'(target_y);
    assign goal_is_victim = carrying;
    assign phase_now      = phase;
    assign substep_now    = substep;

`ifndef SYNTHESIS
    // The input side only stalls while a tick is held
    a_stall_needs_tick: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_vld_reg)
        else $error("in_stall raised with an empty input register");

    // Search never targets a victim
    a_search_no_victim: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_now == rms_pkg::PH_SEARCH) |-> !goal_is_victim)
        else $error("victim goal while searching");

    // Done parks all drivers
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_now == rms_pkg::PH_DONE) |-> (driver_select == rms_pkg::DRV_NONE))
        else $error("driver active in done phase");

    // State only moves when a result is loaded
    a_state_moves_on_step: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(phase_now) && $stable(substep_now)
                     && $stable(driver_select))
        else $error("mission state changed without a tick");
`endif

endmodule

`default_nettype wire

FILE: tb/tb_rescue_mission_sequencer_core.sv
`default_nettype none

module tb_rescue_mission_sequencer_core;

    import rms_pkg::*;

    localparam int CW = PORT_COORD_W;

    typedef struct packed {
        logic                 seen;
        logic signed [CW-1:0] vx;
        logic signed [CW-1:0] vy;
        logic                 angle;
        logic                 lost;
        logic                 done;
        logic signed [CW-1:0] hx;
        logic signed [CW-1:0] hy;
    } tick_t;

    typedef struct packed {
        logic [1:0]           drv;
        logic signed [CW-1:0] gx;
        logic signed [CW-1:0] gy;
        logic                 victim;
        logic [2:0]           phase;
        logic [2:0]           sub;
    } mission_report_t;

    typedef struct packed {
        tick_t           t;
        logic            typed;
        mission_report_t res;
    } tick_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid;
    logic                  in_stall;
    logic                  victim_seen;
    logic signed [CW-1:0]  victim_pos_x;
    logic signed [CW-1:0]  victim_pos_y;
    logic                  angle_wanted;
    logic                  path_lost;
    logic                  path_done;
    logic signed [CW-1:0]  home_x;
    logic signed [CW-1:0]  home_y;
    logic                  out_valid;
    logic                  out_stall;
    logic [1:0]            driver_select;
    logic signed [CW-1:0]  goal_x;
    logic signed [CW-1:0]  goal_y;
    logic                  goal_is_victim;
    logic [2:0]            phase_now;
    logic [2:0]            substep_now;

    // Mission state mirrored by the predictor
    logic [2:0]           m_phase;
    logic [2:0]           m_sub;
    logic [1:0]           m_drv;
    logic signed [CW-1:0] m_target_x;
    logic signed [CW-1:0] m_target_y;
    logic                 m_carrying;
    logic [TIMEOUT_W-1:0] m_ticks;
    logic [TIMEOUT_W-1:0] m_timeout;

    mission_report_t pending_reports[$];
    tick_row_t       directed_rows[$];
    int              error_count;
    int              burst_left;
    int              gap_len;
    bit              allow_finish;

    rescue_mission_sequencer_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .victim_seen    (victim_seen),
        .victim_pos_x   (victim_pos_x),
        .victim_pos_y   (victim_pos_y),
        .angle_wanted   (angle_wanted),
        .path_lost      (path_lost),
        .path_done      (path_done),
        .home_x         (home_x),
        .home_y         (home_y),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .driver_select  (driver_select),
        .goal_x         (goal_x),
        .goal_y         (goal_y),
        .goal_is_victim (goal_is_victim),
        .phase_now      (phase_now),
        .substep_now    (substep_now)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop in case the handshake hangs
    initial
    begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic compare_report(input mission_report_t got, input mission_report_t exp);
        if (got.drv !== exp.drv)
            report_mismatch($sformatf("driver_select got %0d expected %0d", got.drv, exp.drv));
        if (got.gx !== exp.gx)
            report_mismatch($sformatf("goal_x got %0d expected %0d", got.gx, exp.gx));
        if (got.gy !== exp.gy)
            report_mismatch($sformatf("goal_y got %0d expected %0d", got.gy, exp.gy));
        if (got.victim !== exp.victim)
            report_mismatch($sformatf("goal_is_victim got %0d expected %0d",
                                      got.victim, exp.victim));
        if (got.phase !== exp.phase)
            report_mismatch($sformatf("phase_now got %0d expected %0d", got.phase, exp.phase));
        if (got.sub !== exp.sub)
            report_mismatch($sformatf("substep_now got %0d expected %0d", got.sub, exp.sub));
    endtask

    // Drop back to search on an encoding the phase does not allow
    function automatic void recover_mission();
        m_phase    = PH_SEARCH;
        m_sub      = SS_SEARCH;
        m_drv      = DRV_NONE;
        m_carrying = 1'b0;
    endfunction

    // Advance the mirrored mission by one tick and return the reported state
    function automatic mission_report_t step_mission(input tick_t t);
        logic [2:0]           prev_phase;
        logic [TIMEOUT_W-1:0] elapsed;
        mission_report_t      r;
        prev_phase = m_phase;
        case (m_phase)
            PH_SEARCH:
            begin
                if (t.seen)
                begin
                    m_phase    = PH_FOLLOW;
                    m_sub      = SS_TO_VICTIM;
                    m_drv      = DRV_NONE;
                    m_target_x = t.vx;
                    m_target_y = t.vy;
                    m_carrying = 1'b1;
                end
                else if (m_sub == SS_SEARCH)
                begin
                    m_drv = DRV_WALL;
                    if (t.angle)
                    begin
                        m_sub = SS_SENSE;
                        m_drv = DRV_VICTIM;
                    end
                end
                else if (m_sub == SS_SENSE)
                begin
                    if (!t.angle)
                    begin
                        m_sub = SS_WAIT_ANGLE;
                        m_drv = DRV_NONE;
                    end
                end
                else if (m_sub == SS_WAIT_ANGLE)
                begin
                    if (!t.angle)
                    begin
                        m_sub = SS_SEARCH;
                        m_drv = DRV_WALL;
                    end
                end
                else
                    recover_mission();
            end
            PH_FOLLOW:
            begin
                if (t.lost)
                begin
                    m_phase = PH_PRE_NOPATH;
                    m_drv   = DRV_NONE;
                end
                else if (m_sub == SS_TO_VICTIM)
                begin
                    m_drv = DRV_PATH;
                    if (t.done)
                    begin
                        m_sub = SS_WAIT_DONE;
                        m_drv = DRV_NONE;
                    end
                end
                else if (m_sub == SS_WAIT_DONE)
                begin
                    if (!t.done)
                    begin
                        m_sub      = SS_TO_HOME;
                        m_target_x = t.hx;
                        m_target_y = t.hy;
                        m_carrying = 1'b0;
                    end
                end
                else if (m_sub == SS_TO_HOME)
                begin
                    m_drv = DRV_PATH;
                    if (t.done)
                    begin
                        m_phase = PH_DONE;
                        m_drv   = DRV_NONE;
                    end
                end
                else
                    recover_mission();
            end
            PH_PRE_NOPATH:
            begin
                if (!t.lost)
                begin
                    m_phase = PH_NOPATH;
                    m_drv   = DRV_WALL;
                end
            end
            PH_NOPATH:
            begin
                elapsed = (m_ticks == '1) ? m_ticks : m_ticks + TIMEOUT_W'(1);
                if (elapsed >= m_timeout)
                begin
                    m_phase = PH_FOLLOW;
                    m_drv   = DRV_NONE;
                end
            end
            PH_DONE:
            begin
            end
            default:
                recover_mission();
        endcase

        // Restart the phase timer on a phase change, else count and saturate
        if (m_phase != prev_phase)
            m_ticks = '0;
        else if (m_ticks != '1)
            m_ticks = m_ticks + TIMEOUT_W'(1);

        r.drv    = m_drv;
        r.gx     = m_target_x;
        r.gy     = m_target_y;
        r.victim = m_carrying;
        r.phase  = m_phase;
        r.sub    = m_sub;
        return r;
    endfunction

    function automatic tick_t make_tick(input bit seen, input int vx, input int vy,
                                        input bit angle, input bit lost, input bit done,
                                        input int hx, input int hy);
        tick_t t;
        t.seen  = seen;
        t.vx    = vx[CW-1:0];
        t.vy    = vy[CW-1:0];
        t.angle = angle;
        t.lost  = lost;
        t.done  = done;
        t.hx    = hx[CW-1:0];
        t.hy    = hy[CW-1:0];
        return t;
    endfunction

    function automatic mission_report_t make_report(input logic [1:0] drv, input int gx,
                                                    input int gy, input bit victim,
                                                    input logic [2:0] phase,
                                                    input logic [2:0] sub);
        mission_report_t r;
        r.drv    = drv;
        r.gx     = gx[CW-1:0];
        r.gy     = gy[CW-1:0];
        r.victim = victim;
        r.phase  = phase;
        r.sub    = sub;
        return r;
    endfunction

    function automatic void plain_row(input tick_t t);
        tick_row_t row;
        row.t     = t;
        row.typed = 1'b0;
        row.res   = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic void typed_row(input tick_t t, input mission_report_t r);
        tick_row_t row;
        row.t     = t;
        row.typed = 1'b1;
        row.res   = r;
        directed_rows.push_back(row);
    endfunction

    function automatic logic signed [CW-1:0] random_coord();
        case ($urandom_range(0, 7))
            0:       return {1'b1, {(CW-1){1'b0}}};
            1:       return {1'b0, {(CW-1){1'b1}}};
            default: return CW'($urandom);
        endcase
    endfunction

    // Steer the flags so the mission keeps cycling through path loss and
    // recovery; the home target is only reached once the final stretch opens
    function automatic tick_t random_tick();
        tick_t t;
        t.seen  = 1'($urandom_range(0, 1));
        t.vx    = random_coord();
        t.vy    = random_coord();
        t.angle = 1'($urandom_range(0, 1));
        t.hx    = random_coord();
        t.hy    = random_coord();
        case (m_phase)
            PH_FOLLOW:     t.lost = ($urandom_range(0, 9) == 0);
            PH_PRE_NOPATH: t.lost = ($urandom_range(0, 3) != 0);
            default:       t.lost = 1'($urandom_range(0, 1));
        endcase
        if (m_phase == PH_FOLLOW && m_sub == SS_TO_HOME && !allow_finish)
            t.done = 1'b0;
        else if (m_phase == PH_FOLLOW)
            t.done = ($urandom_range(0, 3) == 0);
        else
            t.done = 1'($urandom_range(0, 1));
        return t;
    endfunction

    // Offer one tick transaction, predict it on acceptance, then pace the burst
    task automatic offer_tick(input tick_t t, input bit typed, input mission_report_t typed_res);
        mission_report_t r;
        @(negedge clk);
        in_valid     = 1'b1;
        victim_seen  = t.seen;
        victim_pos_x = t.vx;
        victim_pos_y = t.vy;
        angle_wanted = t.angle;
        path_lost    = t.lost;
        path_done    = t.done;
        home_x       = t.hx;
        home_y       = t.hy;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        r = step_mission(t);
        pending_reports.push_back(typed ? typed_res : r);

        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 30);
            gap_len    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap_len > 0)
            begin
                @(negedge clk);
                in_valid = 1'b0;
                repeat (gap_len - 1)
                    @(negedge clk);
            end
        end
    endtask

    // Hold the input idle until every pending report has been taken
    task automatic drain_pipeline();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (3)
            @(posedge clk);
    endtask

    // Write the no-path timeout while idle, then read it back
    task automatic write_timeout(input logic [TIMEOUT_W-1:0] value);
        drain_pipeline();
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {REG_NO_PATH_TIMEOUT, 2'b00};
        pwdata  = {{(APB_DATA_W-TIMEOUT_W){1'b0}}, value};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        m_timeout = value;
        @(negedge clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== {{(APB_DATA_W-TIMEOUT_W){1'b0}}, value})
            report_mismatch($sformatf("timeout readback got %0d expected %0d", prdata, value));
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Receiver: the stall pattern is redrawn at random, with two long hold-offs
    initial
    begin
        int              rx_cycles;
        int              rx_mode;
        mission_report_t got;
        mission_report_t exp;
        rx_cycles = 0;
        rx_mode   = 0;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            rx_cycles++;
            if (rx_cycles % 64 == 0)
                rx_mode = $urandom_range(0, 2);
            if ((rx_cycles >= 700 && rx_cycles < 900) || (rx_cycles >= 2500 && rx_cycles < 2750))
                out_stall = 1'b1;
            else
                case (rx_mode)
                    0:       out_stall = 1'b0;
                    1:       out_stall = ($urandom_range(0, 2) == 0);
                    default: out_stall = (rx_cycles % 4 == 3);
                endcase
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                got.drv    = driver_select;
                got.gx     = goal_x;
                got.gy     = goal_y;
                got.victim = goal_is_victim;
                got.phase  = phase_now;
                got.sub    = substep_now;
                if (pending_reports.size() == 0)
                    report_mismatch("result transaction with nothing expected");
                else
                begin
                    exp = pending_reports.pop_front();
                    compare_report(got, exp);
                end
            end
        end
    end

    // Sender and run control
    initial
    begin
        logic [TIMEOUT_W-1:0] phase_timeout [6];
        int                   phase_items   [6];
        error_count  = 0;
        burst_left   = 0;
        gap_len      = 0;
        allow_finish = 1'b0;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_valid     = 1'b0;
        victim_seen  = 1'b0;
        victim_pos_x = '0;
        victim_pos_y = '0;
        angle_wanted = 1'b0;
        path_lost    = 1'b0;
        path_done    = 1'b0;
        home_x       = '0;
        home_y       = '0;

        m_phase    = PH_SEARCH;
        m_sub      = SS_SEARCH;
        m_drv      = DRV_NONE;
        m_target_x = '0;
        m_target_y = '0;
        m_carrying = 1'b0;
        m_ticks    = '0;
        m_timeout  = TIMEOUT_RESET;

        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_timeout(24'd2);

        // Walk the search sub-steps
        typed_row(make_tick(0, 0, 0, 0, 0, 0, 0, 0),
                  make_report(DRV_WALL, 0, 0, 0, PH_SEARCH, SS_SEARCH));
        plain_row(make_tick(0, 100, -100, 1, 1, 0, 5, 6));
        plain_row(make_tick(0, 0, 0, 1, 0, 1, 0, 0));
        plain_row(make_tick(0, -1, -1, 0, 0, 0, -1, -1));
        plain_row(make_tick(0, 0, 0, 1, 1, 1, 0, 0));
        plain_row(make_tick(0, 0, 0, 0, 0, 0, 0, 0));
        // Victim seen with extreme coordinates and every other flag set
        typed_row(make_tick(1, -32768, 32767, 1, 1, 1, -1, 0),
                  make_report(DRV_NONE, -32768, 32767, 1, PH_FOLLOW, SS_TO_VICTIM));
        plain_row(make_tick(0, 0, 0, 0, 0, 0, 0, 0));
        // Lose the path, clear the flag, wait out the timeout
        plain_row(make_tick(0, 0, 0, 0, 1, 0, 0, 0));
        plain_row(make_tick(1, 7, 7, 1, 1, 1, 0, 0));
        plain_row(make_tick(0, 0, 0, 0, 0, 0, 0, 0));
        plain_row(make_tick(1, 0, 0, 1, 1, 1, 0, 0));
        plain_row(make_tick(0, 0, 0, 0, 0, 0, 0, 0));
        // Reach the victim, then lose the path while waiting for done to clear
        plain_row(make_tick(0, 0, 0, 0, 0, 1, 0, 0));
        plain_row(make_tick(0, 0, 0, 0, 0, 1, 0, 0));
        plain_row(make_tick(0, 0, 0, 0, 1, 1, 0, 0));
        plain_row(make_tick(0, 0, 0, 0, 0, 0, 0, 0));
        plain_row(make_tick(0, 0, 0, 0, 0, 0, 0, 0));
        plain_row(make_tick(0, 0, 0, 0, 0, 1, 0, 0));
        plain_row(make_tick(0, 0, 0, 0, 0, 1, 0, 0));
        // Done clears: home becomes the target, with extreme coordinates
        typed_row(make_tick(0, 0, 0, 0, 0, 0, 32767, -32768),
                  make_report(DRV_NONE, 32767, -32768, 0, PH_FOLLOW, SS_TO_HOME));
        plain_row(make_tick(0, 0, 0, 0, 0, 0, 0, 0));

        foreach (directed_rows[i])
            offer_tick(directed_rows[i].t, directed_rows[i].typed, directed_rows[i].res);

        // Random phases, each under its own timeout; the maximum one is short
        // and is followed by a small value so a parked no-path phase resumes
        phase_timeout[0] = 24'd1;
        phase_timeout[1] = 24'd0;
        phase_timeout[2] = TIMEOUT_W'($urandom_range(2, 40));
        phase_timeout[3] = 24'hFF_FFFF;
        phase_timeout[4] = 24'd3;
        phase_timeout[5] = TIMEOUT_W'($urandom_range(5, 12));
        phase_items[0]   = 350;
        phase_items[1]   = 300;
        phase_items[2]   = 400;
        phase_items[3]   = 60;
        phase_items[4]   = 400;
        phase_items[5]   = 400;
        for (int p = 0; p < 6; p++)
        begin
            write_timeout(phase_timeout[p]);
            repeat (phase_items[p])
                offer_tick(random_tick(), 1'b0, '0);
        end

        // Final stretch: let the mission reach done and stay there
        allow_finish = 1'b1;
        repeat (40)
            offer_tick(random_tick(), 1'b0, '0);

        drain_pipeline();
        repeat (10)
            @(posedge clk);
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
